[rtl/assert_macros.svh]
// Shared assertion macros for the generator RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define XVG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define XVG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/xvg_pkg.sv]
package xvg_pkg;

	// Generator state geometry
	localparam int unsigned WORD_W  = 64;
	localparam int unsigned WORD_CNT = 16;
	localparam int unsigned PTR_W   = 4;
	localparam int unsigned HALF_W  = WORD_W / 2;

	// Item field widths
	localparam int unsigned KIND_W = 3;
	localparam int unsigned MOD_W  = 31;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_RAW   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RANGE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BERN  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SEL   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SEED  = 3'd4;

	// Scrambler multiplier and xorshift amounts
	localparam logic [WORD_W-1:0] MULT_CONST = 64'h9e37_79b9_7f4a_7c13;
	localparam int unsigned SHIFT_A = 31;
	localparam int unsigned SHIFT_B = 11;
	localparam int unsigned SHIFT_C = 30;

	// Fixed modulus for bernoulli draws (largest 32-bit signed value)
	localparam logic [MOD_W-1:0] BERN_MOD = 31'h7fff_ffff;

	// Status of the modulo unit
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[rtl/xvg_if.sv]
// Input item channel
interface xvg_item_if;
	logic                             valid;
	logic                             ready;
	logic [xvg_pkg::KIND_W-1:0]       kind;
	logic [xvg_pkg::MOD_W-1:0]        bound;
	logic [xvg_pkg::MOD_W-1:0]        threshold;
	logic [xvg_pkg::MOD_W-1:0]        population_left;
	logic [xvg_pkg::MOD_W-1:0]        needed_left;
	logic [xvg_pkg::MOD_W-1:0]        candidate_id;
	logic [xvg_pkg::PTR_W-1:0]        seed_index;
	logic [xvg_pkg::WORD_W-1:0]       seed_value;

	modport source (
		output valid, kind, bound, threshold, population_left, needed_left,
		       candidate_id, seed_index, seed_value,
		input  ready
	);
	modport sink (
		input  valid, kind, bound, threshold, population_left, needed_left,
		       candidate_id, seed_index, seed_value,
		output ready
	);
endinterface

// Result channel
interface xvg_result_if;
	logic                       valid;
	logic                       ready;
	logic [xvg_pkg::WORD_W-1:0] value;
	logic                       hit;
	logic                       error;

	modport source (output valid, value, hit, error, input ready);
	modport sink (input valid, value, hit, error, output ready);
endinterface

[rtl/xvg_ram.sv]
module xvg_ram #(
	parameter int unsigned Width = 64,
	parameter int unsigned Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	// Write one entry, register the read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/xvg_mod_unit.sv]
`include "assert_macros.svh"

// Radix-2 restoring remainder: one dividend bit per cycle.
module xvg_mod_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [xvg_pkg::WORD_W-1:0] dividend,
	input  logic [xvg_pkg::MOD_W-1:0]  modulus,
	output logic [xvg_pkg::MOD_W-1:0]  remainder,
	output xvg_pkg::div_stat_t         stat
);

	localparam int unsigned Steps = xvg_pkg::WORD_W;
	localparam int unsigned CntW  = $clog2(Steps);
	localparam logic [CntW-1:0] CntLast = CntW'(Steps - 1);

	logic                       busy_q;
	logic                       done_q;
	logic [CntW-1:0]            cnt_q;
	logic [xvg_pkg::WORD_W-1:0] dvd_q;
	logic [xvg_pkg::MOD_W-1:0]  mod_q;
	logic [xvg_pkg::MOD_W-1:0]  rem_q;

	logic [xvg_pkg::MOD_W:0] trial;
	logic [xvg_pkg::MOD_W:0] diff;
	logic                    fits;

	// Shift in the next dividend bit and try one subtraction
	assign trial = {rem_q, dvd_q[xvg_pkg::WORD_W-1]};
	assign fits  = (trial >= {1'b0, mod_q});
	assign diff  = trial - {1'b0, mod_q};

	// Control: count the steps, flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CntLast);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntLast) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: load operands, then reduce one bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			mod_q <= modulus;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[xvg_pkg::WORD_W-2:0], 1'b0};
			rem_q <= fits ? diff[xvg_pkg::MOD_W-1:0] : trial[xvg_pkg::MOD_W-1:0];
		end
	end

	assign remainder = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	`XVG_ASSERT_NOW(a_no_restart, start, !busy_q, "modulo unit restarted while busy")
	`XVG_ASSERT_NEXT(a_done_ends, done_q, !busy_q && !done_q, "done pulse not single")

endmodule

[rtl/xorshift1024_variate_generator.sv]
// xorshift1024phi variate generator. Sixteen 64-bit state words live in a
// single-port-write RAM with a registered read; the block handles one item
// at a time. A seed beat writes a word and yields an all-zero result. A raw
// draw reads two words, mixes and writes one back, and scrambles with a
// 64x64 multiply split into three 32x32 partial products. Bernoulli draws
// fold the draw modulo 2^31-1 with end-around adds in an extra FOLD state.
// Range and selection draws reduce the draw modulo a 31-bit value in a
// radix-2 remainder unit, one bit per cycle; they are the slowest items. A
// zero modulus skips the reduction and reports error. The next item is taken
// once the result sits in the output register, even while that result still
// waits to be taken. State words must be seeded before they are drawn from;
// they are not cleared by reset.
`include "assert_macros.svh"

module xorshift1024_variate_generator (
	input  logic                clk,
	input  logic                arst_n,
	xvg_item_if.sink            item,
	xvg_result_if.source        result
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD1  = 4'd1;
	localparam logic [3:0] S_MIX  = 4'd2;
	localparam logic [3:0] S_MUL0 = 4'd3;
	localparam logic [3:0] S_MUL1 = 4'd4;
	localparam logic [3:0] S_MUL2 = 4'd5;
	localparam logic [3:0] S_SUM  = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;
	localparam logic [3:0] S_FOLD = 4'd9;

	localparam int unsigned WW = xvg_pkg::WORD_W;
	localparam int unsigned HW = xvg_pkg::HALF_W;
	localparam int unsigned MW = xvg_pkg::MOD_W;

	logic [3:0]                 state_q;
	logic [xvg_pkg::PTR_W-1:0]  ptr_q;

	logic [xvg_pkg::KIND_W-1:0] kind_q;
	logic [MW-1:0]              bound_q;
	logic [MW-1:0]              thresh_q;
	logic [MW-1:0]              pop_q;
	logic [MW-1:0]              need_q;
	logic [MW-1:0]              cand_q;

	logic [WW-1:0]              s0_q;
	logic [WW-1:0]              mix_q;
	logic [WW-1:0]              pp0_q;
	logic [HW-1:0]              pp1_q;
	logic [HW-1:0]              pp2_q;
	logic [WW-1:0]              draw_q;
	logic [MW+1:0]              fold_q;

	logic                       out_valid_q;
	logic [WW-1:0]              out_value_q;
	logic                       out_hit_q;
	logic                       out_err_q;

	logic                       accept;
	logic                       seed_wr;
	logic [xvg_pkg::PTR_W-1:0]  ptr_nx;
	logic                       ram_we;
	logic [xvg_pkg::PTR_W-1:0]  ram_waddr;
	logic [WW-1:0]              ram_wdata;
	logic [xvg_pkg::PTR_W-1:0]  ram_raddr;
	logic [WW-1:0]              ram_rdata;

	logic [WW-1:0]              s1x;
	logic [WW-1:0]              mix_word;
	logic [HW-1:0]              cross_sum;
	logic [WW-1:0]              draw_sum;

	logic [MW+1:0]              fold_sum;
	logic [MW:0]                fold_wrap;
	logic [MW-1:0]              bern_rem;

	logic [MW-1:0]              mod_sel;
	logic                       mod_zero;
	logic                       div_start;
	logic [MW-1:0]              div_rem;
	xvg_pkg::div_stat_t         div_stat;

	logic                       out_load;
	logic [WW-1:0]              res_value;
	logic                       res_hit;
	logic                       res_err;

	assign accept  = item.valid && item.ready;
	assign seed_wr = accept && (item.kind == xvg_pkg::KIND_SEED);
	assign ptr_nx  = ptr_q + 1'b1;

	// State word memory: seed writes on accept, mixed word writes in MIX
	assign ram_we    = seed_wr || (state_q == S_MIX);
	assign ram_waddr = seed_wr ? item.seed_index : ptr_nx;
	assign ram_wdata = seed_wr ? item.seed_value : mix_word;
	assign ram_raddr = (state_q == S_RD1) ? ptr_nx : ptr_q;

	xvg_ram #(
		.Width (xvg_pkg::WORD_W),
		.Depth (xvg_pkg::WORD_CNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Xorshift mix of the two words
	assign s1x      = ram_rdata ^ (ram_rdata << xvg_pkg::SHIFT_A);
	assign mix_word = s1x ^ s0_q ^ (s1x >> xvg_pkg::SHIFT_B) ^ (s0_q >> xvg_pkg::SHIFT_C);

	// Low 64 bits of the scrambling product from the partial products
	assign cross_sum = pp1_q + pp2_q;
	assign draw_sum  = pp0_q + {cross_sum, {HW{1'b0}}};

	// Fold the draw modulo 2^31-1: add the 31-bit chunks, wrap the carry, trim once
	assign fold_sum  = {2'b00, draw_q[MW-1:0]} + {2'b00, draw_q[2*MW-1:MW]}
		+ {{MW{1'b0}}, draw_q[WW-1:2*MW]};
	assign fold_wrap = {1'b0, fold_q[MW-1:0]} + {{(MW-1){1'b0}}, fold_q[MW+1:MW]};
	assign bern_rem  = (fold_wrap >= {1'b0, xvg_pkg::BERN_MOD})
		? MW'(fold_wrap - {1'b0, xvg_pkg::BERN_MOD}) : fold_wrap[MW-1:0];

	// Pick the modulus for this kind
	always_comb begin
		case (kind_q)
			xvg_pkg::KIND_RANGE: mod_sel = bound_q;
			xvg_pkg::KIND_SEL:   mod_sel = pop_q;
			default:             mod_sel = '0;
		endcase
	end

	assign mod_zero  = (mod_sel == '0);
	assign div_start = (state_q == S_SUM) && !mod_zero
		&& ((kind_q == xvg_pkg::KIND_RANGE) || (kind_q == xvg_pkg::KIND_SEL));

	xvg_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (draw_sum),
		.modulus   (mod_sel),
		.remainder (div_rem),
		.stat      (div_stat)
	);

	// Sequencer and draw pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ptr_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (item.kind) inside
							xvg_pkg::KIND_RAW, xvg_pkg::KIND_RANGE,
							xvg_pkg::KIND_BERN, xvg_pkg::KIND_SEL: state_q <= S_RD1;
							default:                               state_q <= S_DONE;
						endcase
					end
				end
				S_RD1:  state_q <= S_MIX;
				S_MIX: begin
					ptr_q   <= ptr_nx;
					state_q <= S_MUL0;
				end
				S_MUL0: state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_SUM;
				S_SUM: begin
					if (kind_q == xvg_pkg::KIND_BERN) begin
						state_q <= S_FOLD;
					end else if (div_start) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_FOLD: state_q <= S_DONE;
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture the item and run the draw datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= item.kind;
			bound_q  <= item.bound;
			thresh_q <= item.threshold;
			pop_q    <= item.population_left;
			need_q   <= item.needed_left;
			cand_q   <= item.candidate_id;
		end
		if (state_q == S_RD1) begin
			s0_q <= ram_rdata;
		end
		if (state_q == S_MIX) begin
			mix_q <= mix_word;
		end
		if (state_q == S_MUL0) begin
			pp0_q <= mix_q[HW-1:0] * xvg_pkg::MULT_CONST[HW-1:0];
		end
		if (state_q == S_MUL1) begin
			pp1_q <= HW'(mix_q[HW-1:0] * xvg_pkg::MULT_CONST[WW-1:HW]);
		end
		if (state_q == S_MUL2) begin
			pp2_q <= HW'(mix_q[WW-1:HW] * xvg_pkg::MULT_CONST[HW-1:0]);
		end
		if (state_q == S_SUM) begin
			draw_q <= draw_sum;
		end
		if (state_q == S_FOLD) begin
			fold_q <= fold_sum;
		end
	end

	// Form the result of the finished item
	always_comb begin
		res_value = '0;
		res_hit   = 1'b0;
		res_err   = 1'b0;
		case (kind_q)
			xvg_pkg::KIND_RAW: res_value = draw_q;
			xvg_pkg::KIND_RANGE: begin
				if (mod_zero) begin
					res_err = 1'b1;
				end else begin
					res_value = {{(WW - MW){1'b0}}, div_rem};
				end
			end
			xvg_pkg::KIND_BERN: res_hit = (bern_rem < thresh_q);
			xvg_pkg::KIND_SEL: begin
				if (mod_zero) begin
					res_err = 1'b1;
				end else if (div_rem < need_q) begin
					res_hit   = 1'b1;
					res_value = {{(WW - MW){1'b0}}, cand_q};
				end
			end
			default: ;
		endcase
	end

	// Output register: load when empty or being drained
	assign out_load = (state_q == S_DONE) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !result.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= res_value;
			out_hit_q   <= res_hit;
			out_err_q   <= res_err;
		end
	end

	assign item.ready    = (state_q == S_IDLE);
	assign result.valid  = out_valid_q;
	assign result.value  = out_value_q;
	assign result.hit    = out_hit_q;
	assign result.error  = out_err_q;

	`XVG_ASSERT_NEXT(a_busy_after_accept, accept, state_q != S_IDLE, "accepted beat not held")
	`XVG_ASSERT_NEXT(a_ptr_step, state_q == S_MIX, ptr_q == $past(ptr_q) + 4'd1, "pointer skipped")
	`XVG_ASSERT_NOW(a_err_clean, out_valid_q && out_err_q,
		!out_hit_q && (out_value_q == '0), "error result carries data")
	`XVG_ASSERT_NOW(a_div_only_waiting, div_stat.done, state_q == S_DIV, "stray modulo result")

endmodule
